### design/assert_macros.svh
// Assertion helpers shared by the design files.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PMPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pmpd implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pmpd next-cycle check failed");

`else

`define PMPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/pmpd_pkg.sv
package pmpd_pkg;

	// Memory geometry.
	localparam int BANK_BYTES = 16384;
	localparam int RAM_BANKS  = 8;
	localparam int ROM_BANKS  = 2;
	localparam int OFFSET_W   = $clog2(BANK_BYTES);
	localparam int BANK_W     = $clog2(RAM_BANKS);
	localparam int RAM_DEPTH  = RAM_BANKS * BANK_BYTES;
	localparam int ROM_DEPTH  = ROM_BANKS * BANK_BYTES;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int ROM_AW     = $clog2(ROM_DEPTH);

	// Bus operation codes.
	localparam logic [2:0] OP_MEM_READ  = 3'd0;
	localparam logic [2:0] OP_MEM_WRITE = 3'd1;
	localparam logic [2:0] OP_IO_READ   = 3'd2;
	localparam logic [2:0] OP_IO_WRITE  = 3'd3;
	localparam logic [2:0] OP_ROM_LOAD  = 3'd4;

	// Address windows of the CPU space.
	localparam logic [1:0] WIN_ROM  = 2'd0;
	localparam logic [1:0] WIN_LOW  = 2'd1;
	localparam logic [1:0] WIN_MID  = 2'd2;

	// Fixed bank numbers.
	localparam logic [BANK_W-1:0] BANK_SCREEN     = 3'd5;
	localparam logic [BANK_W-1:0] BANK_SCREEN_ALT = 3'd7;
	localparam logic [BANK_W-1:0] BANK_MID        = 3'd2;

	// Paging latch bit positions.
	localparam int LATCH_SCREEN_BIT = 3;
	localparam int LATCH_ROM_BIT    = 4;
	localparam int LATCH_LOCK_BIT   = 5;

	// Port decode bytes.
	localparam logic [7:0] PORT_LO_FD      = 8'hFD;
	localparam logic [7:0] PORT_LO_FE      = 8'hFE;
	localparam logic [7:0] PORT_HI_PAGE    = 8'h7F;
	localparam logic [7:0] PORT_HI_AY_DATA = 8'hBF;
	localparam logic [7:0] PORT_HI_AY_REG  = 8'hFF;

	// Source of the read data of a result.
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_RAM,
		SRC_ROM,
		SRC_IO
	} rd_src_t;

	// One bus access.
	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [14:0] rom_address;
		logic [7:0]  external_data;
	} req_t;

	// One result.
	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] border_color;
		logic [1:0] speaker_level;
		logic       ay_select_strobe;
		logic       ay_write_strobe;
		logic       ay_read_strobe;
		logic [7:0] ay_data;
		logic [7:0] paging_value;
	} rsp_t;

	// Decoded controls for one access.
	typedef struct packed {
		logic              ram_we;
		logic [RAM_AW-1:0] ram_addr;
		logic              rom_we;
		logic [ROM_AW-1:0] rom_addr;
		rd_src_t           rd_src;
		logic [7:0]        io_data;
		logic              latch_we;
		logic              fe_we;
		logic              ay_sel;
		logic              ay_wr;
		logic              ay_rd;
		logic [7:0]        ay_data;
	} ctl_t;

endpackage

### design/pmpd_ram.sv
module pmpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, write and registered read at the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### design/pmpd_decode.sv
module pmpd_decode (
	input  pmpd_pkg::req_t     req,
	input  logic [7:0]         latch,
	output pmpd_pkg::ctl_t     ctl
);
	import pmpd_pkg::*;

	logic [7:0]        hi;
	logic [7:0]        lo;
	logic [1:0]        window;
	logic              fd_open;
	logic [BANK_W-1:0] bank;

	assign hi      = req.address[15:8];
	assign lo      = req.address[7:0];
	assign window  = req.address[15:14];
	assign fd_open = (lo == PORT_LO_FD) && !latch[LATCH_LOCK_BIT];

	// RAM bank behind each upper window.
	always_comb begin
		unique case (window)
			WIN_LOW: bank = latch[LATCH_SCREEN_BIT] ? BANK_SCREEN_ALT : BANK_SCREEN;
			WIN_MID: bank = BANK_MID;
			default: bank = latch[BANK_W-1:0];
		endcase
	end

	// Operation decode.
	always_comb begin
		ctl          = '0;
		ctl.rd_src   = SRC_ZERO;
		ctl.ram_addr = {bank, req.address[OFFSET_W-1:0]};
		ctl.rom_addr = {latch[LATCH_ROM_BIT], req.address[OFFSET_W-1:0]};
		ctl.io_data  = req.external_data;
		unique case (req.operation)
			OP_MEM_READ: begin
				ctl.rd_src = (window == WIN_ROM) ? SRC_ROM : SRC_RAM;
			end
			OP_MEM_WRITE: begin
				// Writes into the ROM window are dropped.
				ctl.ram_we = (window != WIN_ROM);
			end
			OP_IO_READ: begin
				ctl.rd_src = SRC_IO;
				if (fd_open && hi == PORT_HI_PAGE) begin
					ctl.io_data = latch;
				end
				ctl.ay_rd = fd_open && (hi == PORT_HI_AY_REG);
			end
			OP_IO_WRITE: begin
				ctl.fe_we    = (lo == PORT_LO_FE);
				ctl.latch_we = fd_open && (hi == PORT_HI_PAGE);
				ctl.ay_wr    = fd_open && (hi == PORT_HI_AY_DATA);
				ctl.ay_sel   = fd_open && (hi == PORT_HI_AY_REG);
				if (ctl.ay_wr || ctl.ay_sel) begin
					ctl.ay_data = req.write_data;
				end
			end
			OP_ROM_LOAD: begin
				ctl.rom_we   = 1'b1;
				ctl.rom_addr = req.rom_address;
			end
			default: begin
				ctl.rd_src = SRC_ZERO;
			end
		endcase
	end

endmodule

### design/paged_memory_and_port_decoder_unit.sv
// Paged memory and I/O port decoder. After reset the unit runs a clearing
// pass that writes zero to all 131072 RAM bytes, one byte per cycle; busy is
// high during that pass and no request is taken. From then on busy stays low
// and one request is taken in every cycle in which start is high. Each request
// gives one result, marked by done. The request passes through the input
// register while the paging, port and memory decode runs and the RAM or ROM
// is addressed, then through the result register while the registered memory
// read data comes back. Results leave in request order and must be taken when
// shown; the receiver cannot stall the unit. The ROM holds no defined data
// until it has been loaded.
`include "assert_macros.svh"

module paged_memory_and_port_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pmpd_pkg::req_t request,
	output logic           done,
	output pmpd_pkg::rsp_t result
);
	import pmpd_pkg::*;

	// Clearing pass state.
	logic              clear_q;
	logic [RAM_AW-1:0] clr_cnt_q;

	// Input register.
	logic valid_s1;
	req_t req_s1;

	// Result register.
	logic       valid_s2;
	rd_src_t    src_s2;
	logic [7:0] io_data_s2;
	logic       ay_sel_s2;
	logic       ay_wr_s2;
	logic       ay_rd_s2;
	logic [7:0] ay_data_s2;

	// Architectural registers.
	logic [7:0] latch_q;
	logic [2:0] border_q;
	logic [1:0] speaker_q;

	ctl_t              ctl;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic [7:0]        rom_rdata;
	logic              accept;

	assign busy   = clear_q;
	assign accept = start && !busy;

	// Clearing pass over the whole RAM after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
	end

	pmpd_decode u_decode (
		.req   (req_s1),
		.latch (latch_q),
		.ctl   (ctl)
	);

	// RAM port is owned by the clearing pass until it ends.
	assign ram_we    = clear_q || (valid_s1 && ctl.ram_we);
	assign ram_addr  = clear_q ? clr_cnt_q : ctl.ram_addr;
	assign ram_wdata = clear_q ? 8'h00 : req_s1.write_data;

	pmpd_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	pmpd_ram #(
		.WIDTH (8),
		.DEPTH (ROM_DEPTH)
	) u_rom (
		.clk   (clk),
		.we    (valid_s1 && ctl.rom_we),
		.addr  (ctl.rom_addr),
		.wdata (req_s1.write_data),
		.rdata (rom_rdata)
	);

	// Paging latch, border and speaker updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q   <= '0;
			border_q  <= '0;
			speaker_q <= '0;
		end else if (valid_s1) begin
			if (ctl.latch_we) begin
				latch_q <= req_s1.write_data;
			end
			if (ctl.fe_we) begin
				border_q  <= req_s1.write_data[2:0];
				speaker_q <= req_s1.write_data[4:3];
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			ay_sel_s2 <= 1'b0;
			ay_wr_s2  <= 1'b0;
			ay_rd_s2  <= 1'b0;
		end else begin
			valid_s2  <= valid_s1;
			ay_sel_s2 <= valid_s1 && ctl.ay_sel;
			ay_wr_s2  <= valid_s1 && ctl.ay_wr;
			ay_rd_s2  <= valid_s1 && ctl.ay_rd;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			src_s2     <= ctl.rd_src;
			io_data_s2 <= ctl.io_data;
			ay_data_s2 <= ctl.ay_data;
		end
	end

	// Read data selection and result assembly.
	always_comb begin
		result = '0;
		case (src_s2)
			SRC_RAM: result.read_data = ram_rdata;
			SRC_ROM: result.read_data = rom_rdata;
			SRC_IO:  result.read_data = io_data_s2;
			default: result.read_data = 8'h00;
		endcase
		result.border_color     = border_q;
		result.speaker_level    = speaker_q;
		result.ay_select_strobe = ay_sel_s2;
		result.ay_write_strobe  = ay_wr_s2;
		result.ay_read_strobe   = ay_rd_s2;
		result.ay_data          = ay_data_s2;
		result.paging_value     = latch_q;
	end

	assign done = valid_s2;

	// No request enters while the clearing pass owns the RAM.
	`PMPD_ASSERT_NEXT(a_no_accept_in_clear, clk, arst_n, clear_q, !valid_s1)
	// At most one AY strobe per result.
	`PMPD_ASSERT_IMPLY(a_ay_onehot, clk, arst_n, 1'b1, $onehot0({ay_sel_s2, ay_wr_s2, ay_rd_s2}))
	// Strobes only appear together with a result.
	`PMPD_ASSERT_IMPLY(a_strobe_done, clk, arst_n, ay_sel_s2 || ay_wr_s2 || ay_rd_s2, done)
	// The paging latch changes only from a decoded write to its port.
	`PMPD_ASSERT_IMPLY(a_latch_write, clk, arst_n, !$stable(latch_q), $past(valid_s1 && ctl.latch_we))

endmodule

### sim/tb.sv
module tb;
	import pmpd_pkg::*;

	// Operation codes that the unit does not decode.
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
	// Joystick port, read back as external data.
	localparam logic [7:0] PORT_LO_JOY     = 8'h1F;
	// Nothing is accepted during the clearing pass after reset.
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 500;
	localparam int LOCKED_TAIL = 50;

	typedef struct {
		req_t access;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;

	// Shadow copy of the unit's state.
	logic [7:0] page_latch = '0;
	logic [2:0] border_q = '0;
	logic [1:0] speaker_q = '0;
	bit [7:0] ram_img [RAM_DEPTH];
	bit [7:0] rom_img [ROM_DEPTH];
	bit rom_loaded [ROM_DEPTH];

	rsp_t bus_results_due[$];
	plan_row_t plan_q[$];
	int idle_pct = 0;
	int fail_count = 0;
	int stall_cycles = 0;
	int locked_first;

	paged_memory_and_port_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic req_t make_req(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] wdata, input logic [14:0] raddr, input logic [7:0] ext);
		req_t r;
		r.operation = op;
		r.address = addr;
		r.write_data = wdata;
		r.rom_address = raddr;
		r.external_data = ext;
		return r;
	endfunction

	function automatic rsp_t make_rsp(input logic [7:0] rdata, input logic [2:0] border,
			input logic [1:0] spk, input logic [7:0] page);
		rsp_t o;
		o = '0;
		o.read_data = rdata;
		o.border_color = border;
		o.speaker_level = spk;
		o.paging_value = page;
		return o;
	endfunction

	function automatic void add_row(input req_t access, input bit typed, input rsp_t want);
		plan_row_t row;
		row.access = access;
		row.typed = typed;
		row.want = want;
		plan_q.push_back(row);
	endfunction

	// Computes the result of one bus access and updates the shadow state.
	function automatic rsp_t predict_bus_access(input req_t r);
		rsp_t o;
		logic [7:0] lo_b;
		logic [7:0] hi_b;
		logic fd_open;
		logic [BANK_W-1:0] bank;
		logic [RAM_AW-1:0] ram_idx;
		logic [ROM_AW-1:0] rom_idx;
		o = '0;
		lo_b = r.address[7:0];
		hi_b = r.address[15:8];
		fd_open = (lo_b == PORT_LO_FD) && !page_latch[LATCH_LOCK_BIT];
		case (r.address[15:14])
			WIN_LOW: bank = page_latch[LATCH_SCREEN_BIT] ? BANK_SCREEN_ALT : BANK_SCREEN;
			WIN_MID: bank = BANK_MID;
			default: bank = page_latch[BANK_W-1:0];
		endcase
		ram_idx = {bank, r.address[OFFSET_W-1:0]};
		rom_idx = {page_latch[LATCH_ROM_BIT], r.address[OFFSET_W-1:0]};
		case (r.operation)
			OP_MEM_READ: begin
				if (r.address[15:14] == WIN_ROM)
					o.read_data = rom_img[rom_idx];
				else
					o.read_data = ram_img[ram_idx];
			end
			OP_MEM_WRITE: begin
				// Writes into the ROM window are dropped.
				if (r.address[15:14] != WIN_ROM)
					ram_img[ram_idx] = r.write_data;
			end
			OP_IO_READ: begin
				o.read_data = r.external_data;
				if (fd_open) begin
					if (hi_b == PORT_HI_PAGE)
						o.read_data = page_latch;
					else if (hi_b == PORT_HI_AY_REG)
						o.ay_read_strobe = 1'b1;
				end
			end
			OP_IO_WRITE: begin
				if (lo_b == PORT_LO_FE) begin
					speaker_q = r.write_data[4:3];
					border_q = r.write_data[2:0];
				end
				if (fd_open) begin
					if (hi_b == PORT_HI_PAGE) begin
						page_latch = r.write_data;
					end else if (hi_b == PORT_HI_AY_DATA) begin
						o.ay_write_strobe = 1'b1;
						o.ay_data = r.write_data;
					end else if (hi_b == PORT_HI_AY_REG) begin
						o.ay_select_strobe = 1'b1;
						o.ay_data = r.write_data;
					end
				end
			end
			OP_ROM_LOAD: begin
				rom_img[r.rom_address] = r.write_data;
				rom_loaded[r.rom_address] = 1'b1;
			end
			default: ;
		endcase
		o.border_color = border_q;
		o.speaker_level = speaker_q;
		o.paging_value = page_latch;
		return o;
	endfunction

	// Offsets cluster at both ends of a bank so that reads find earlier writes.
	function automatic logic [OFFSET_W-1:0] pick_offset();
		logic [OFFSET_W-1:0] off;
		case ($urandom_range(0, 3))
			0: off = OFFSET_W'($urandom);
			1: off = {8'hFF, 6'($urandom_range(0, 63))};
			default: off = OFFSET_W'($urandom_range(0, 63));
		endcase
		return off;
	endfunction

	// Draws one random bus access from the current shadow state.
	function automatic req_t random_access(input bit allow_lock);
		req_t r;
		int pick;
		logic [7:0] hi_b;
		logic [7:0] lo_b;
		logic [ROM_AW-1:0] ridx;
		r = make_req(OP_MEM_READ, 16'($urandom), 8'($urandom), 15'($urandom), 8'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 32) begin
			r.address = {2'($urandom), pick_offset()};
			// A ROM byte that was never loaded is loaded instead of read.
			if (r.address[15:14] == WIN_ROM) begin
				ridx = {page_latch[LATCH_ROM_BIT], r.address[OFFSET_W-1:0]};
				if (!rom_loaded[ridx]) begin
					r.operation = OP_ROM_LOAD;
					r.rom_address = ridx;
				end
			end
		end else if (pick < 56) begin
			r.operation = OP_MEM_WRITE;
			r.address = {2'($urandom), pick_offset()};
		end else if (pick < 64) begin
			r.operation = OP_ROM_LOAD;
			r.rom_address = {1'($urandom), pick_offset()};
		end else if (pick < 98) begin
			r.operation = (pick < 78) ? OP_IO_READ : OP_IO_WRITE;
			case ($urandom_range(0, 3))
				0: hi_b = PORT_HI_PAGE;
				1: hi_b = PORT_HI_AY_DATA;
				2: hi_b = PORT_HI_AY_REG;
				default: hi_b = 8'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0, 1, 2: lo_b = PORT_LO_FD;
				3: lo_b = PORT_LO_FE;
				4: lo_b = PORT_LO_JOY;
				default: lo_b = 8'($urandom);
			endcase
			r.address = {hi_b, lo_b};
			// The lock cannot be undone without a reset, so it is held back.
			if (!allow_lock && r.operation == OP_IO_WRITE && lo_b == PORT_LO_FD
					&& hi_b == PORT_HI_PAGE)
				r.write_data[LATCH_LOCK_BIT] = 1'b0;
		end else begin
			r.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
		end
		return r;
	endfunction

	// Presents one request, waits for it to be taken and records its expected result.
	task automatic send_access(input req_t access, input bit typed, input rsp_t want);
		rsp_t model;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		start <= 1'b1;
		request <= access;
		do @(posedge clk); while (busy);
		model = predict_bus_access(access);
		bus_results_due.push_back(typed ? want : model);
	endtask

	task automatic walk_rows(input int first, input int last);
		for (int i = first; i < last; i++)
			send_access(plan_q[i].access, plan_q[i].typed, plan_q[i].want);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Stimulus: directed rows, random phases, the locked-port rows, then a random tail.
	initial begin
		rsp_t zero_rsp;
		zero_rsp = make_rsp(8'h00, 3'd0, 2'd0, 8'h00);

		// Fresh state after reset, ROM loads at both ends of the store.
		add_row(make_req(OP_MEM_READ, 16'hFFFF, 8'h00, 15'h0000, 8'hFF), 1'b1, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'h4000, 8'hFF, 15'h7FFF, 8'h00), 1'b1, zero_rsp);
		add_row(make_req(OP_ROM_LOAD, 16'h0000, 8'hA5, 15'h0000, 8'h00), 1'b1, zero_rsp);
		add_row(make_req(OP_ROM_LOAD, 16'hFFFF, 8'hFF, 15'h7FFF, 8'hFF), 1'b1, zero_rsp);
		add_row(make_req(OP_ROM_LOAD, 16'h0000, 8'h3C, 15'h3FFF, 8'h00), 1'b1, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'h0000, 8'h00, 15'h0000, 8'h00), 1'b1,
			make_rsp(8'hA5, 3'd0, 2'd0, 8'h00));
		add_row(make_req(OP_MEM_READ, 16'h3FFF, 8'h00, 15'h0000, 8'h00), 1'b1,
			make_rsp(8'h3C, 3'd0, 2'd0, 8'h00));
		// A write into the ROM window leaves the ROM unchanged.
		add_row(make_req(OP_MEM_WRITE, 16'h0000, 8'h11, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'h0000, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		// Border and speaker, then reads of the keyboard and joystick ports.
		add_row(make_req(OP_IO_WRITE, 16'h00FE, 8'hFF, 15'h0000, 8'h00), 1'b1,
			make_rsp(8'h00, 3'd7, 2'd3, 8'h00));
		add_row(make_req(OP_IO_READ, 16'h00FE, 8'h00, 15'h0000, 8'h5A), 1'b1,
			make_rsp(8'h5A, 3'd7, 2'd3, 8'h00));
		add_row(make_req(OP_IO_READ, 16'h001F, 8'h00, 15'h0000, 8'hC3), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'h00FE, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		// Paging: ROM half 1, alternate screen bank, bank 7 at C000.
		add_row(make_req(OP_IO_WRITE, 16'h7FFD, 8'h1F, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_READ, 16'h7FFD, 8'h00, 15'h0000, 8'hE1), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'h3FFF, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_WRITE, 16'hC000, 8'h77, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'h4000, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_WRITE, 16'hBFFF, 8'hFF, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'hBFFF, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		// Sound chip ports and an unclaimed port.
		add_row(make_req(OP_IO_WRITE, 16'hFFFD, 8'h0E, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'hBFFD, 8'hAA, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_READ, 16'hFFFD, 8'h00, 15'h0000, 8'h99), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'h1234, 8'hFF, 15'h0000, 8'h00), 1'b0, zero_rsp);
		// Undecoded operations.
		add_row(make_req(OP_FIRST_UNUSED, 16'hFFFF, 8'hFF, 15'h7FFF, 8'hFF), 1'b0, zero_rsp);
		add_row(make_req(OP_LAST_UNUSED, 16'h7FFD, 8'hFF, 15'h0000, 8'hFF), 1'b0, zero_rsp);
		locked_first = plan_q.size();
		// Locked ports: only the setting write reaches the paging and sound chip ports.
		add_row(make_req(OP_IO_WRITE, 16'h7FFD, 8'h3F, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'h7FFD, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_READ, 16'h7FFD, 8'h00, 15'h0000, 8'h3C), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'hFFFD, 8'h55, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'hBFFD, 8'h66, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_READ, 16'hFFFD, 8'h00, 15'h0000, 8'h77), 1'b0, zero_rsp);
		add_row(make_req(OP_IO_WRITE, 16'h00FE, 8'h1D, 15'h0000, 8'h00), 1'b0, zero_rsp);
		add_row(make_req(OP_MEM_READ, 16'hC000, 8'h00, 15'h0000, 8'h00), 1'b0, zero_rsp);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		walk_rows(0, locked_first);
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 12 : (phase == 1) ? 46 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_access(random_access(1'b0), 1'b0, zero_rsp);
		end
		idle_pct = 12;
		walk_rows(locked_first, plan_q.size());
		for (int n = 0; n < LOCKED_TAIL; n++)
			send_access(random_access(1'b1), 1'b0, zero_rsp);
		start <= 1'b0;

		while (bus_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Compare each result with the oldest outstanding one.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (bus_results_due.size() == 0) begin
				fail_count++;
				$display("%0t: result with no request waiting, expected none actual %0h",
					$time, result);
			end else begin
				want = bus_results_due.pop_front();
				check_field("read_data", want.read_data, result.read_data);
				check_field("border_color", 8'(want.border_color), 8'(result.border_color));
				check_field("speaker_level", 8'(want.speaker_level),
					8'(result.speaker_level));
				check_field("ay_select_strobe", 8'(want.ay_select_strobe),
					8'(result.ay_select_strobe));
				check_field("ay_write_strobe", 8'(want.ay_write_strobe),
					8'(result.ay_write_strobe));
				check_field("ay_read_strobe", 8'(want.ay_read_strobe),
					8'(result.ay_read_strobe));
				check_field("ay_data", want.ay_data, result.ay_data);
				check_field("paging_value", want.paging_value, result.paging_value);
			end
		end
	end

	// Watchdog on cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: timeout after %0d idle cycles", $time, stall_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

### sim.f
+incdir+design
design/pmpd_pkg.sv
design/pmpd_ram.sv
design/pmpd_decode.sv
design/paged_memory_and_port_decoder_unit.sv
sim/tb.sv
